// ===== design/msfr_pkg.sv =====
package msfr_pkg;

	localparam int COUNT_BITS = 24;
	localparam int FIELD_BITS = 24;
	localparam int PWM_BITS   = 20;
	localparam int FREQ_BITS  = 9;
	localparam int STEP_BITS  = 16;
	localparam int CFG_BITS   = 20;
	localparam int IDX_BITS   = 2;

	// dividend is pwm_freq_hz * 4
	localparam int QUOT_BITS = PWM_BITS + 2;
	localparam int DCNT_BITS = $clog2(QUOT_BITS);

	localparam logic [IDX_BITS-1:0] REG_PWM_FREQ     = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_START_FREQ   = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_PERIODS_STEP = 2'd2;

	localparam logic [PWM_BITS-1:0]  PWM_FREQ_RST   = PWM_BITS'(20000);
	localparam logic [FREQ_BITS-1:0] START_FREQ_RST = FREQ_BITS'(20);
	localparam logic [STEP_BITS-1:0] PERIODS_RST    = STEP_BITS'(10);

	localparam logic [FREQ_BITS-1:0]  FREQ_STOP_Q = FREQ_BITS'(500);
	localparam logic [FREQ_BITS-1:0]  FREQ_FULL_Q = FREQ_BITS'(200);
	localparam logic [COUNT_BITS-1:0] CNT_MAX     = '1;
	localparam logic [STEP_BITS-1:0]  PERIODS_MAX = '1;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [FIELD_BITS-1:0] field_t;
	typedef logic [FREQ_BITS-1:0]  freq_t;

	typedef enum logic [1:0] {
		MODE_WAIT_FIRST  = 2'd0,
		MODE_WAIT_SECOND = 2'd1,
		MODE_RAMP        = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_DIV,
		SEQ_PUB
	} seq_t;

	typedef struct packed {
		logic                 start;
		logic [QUOT_BITS-1:0] dividend;
		freq_t                divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [QUOT_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== design/msfr_if.sv =====
interface msfr_in_if;
	import msfr_pkg::*;

	logic valid;
	logic ready;
	logic hall_flag;

	modport source (output valid, output hall_flag, input ready);
	modport sink (input valid, input hall_flag, output ready);
endinterface

interface msfr_out_if;
	import msfr_pkg::*;

	logic   valid;
	logic   ready;
	field_t phase_tick;
	field_t period_ticks;
	freq_t  sine_freq_q;
	logic   full_amplitude;
	field_t hall_period;
	logic [1:0] mode;

	modport source (
		output valid, output phase_tick, output period_ticks, output sine_freq_q,
		output full_amplitude, output hall_period, output mode, input ready
	);
	modport sink (
		input valid, input phase_tick, input period_ticks, input sine_freq_q,
		input full_amplitude, input hall_period, input mode, output ready
	);
endinterface

// ===== design/msfr_div.sv =====
module msfr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  msfr_pkg::div_req_t req,
	output msfr_pkg::div_rsp_t rsp
);
	import msfr_pkg::*;

	logic [QUOT_BITS-1:0] dvd_q;
	freq_t                dvs_q;
	freq_t                rem_q;
	logic [DCNT_BITS-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [FREQ_BITS:0] rem_sh;
	logic               ge;

	// restoring division, one quotient bit per cycle shifted into the dividend
	assign rem_sh = {rem_q, dvd_q[QUOT_BITS-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_BITS'(QUOT_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? FREQ_BITS'(rem_sh - {1'b0, dvs_q}) : FREQ_BITS'(rem_sh);
			dvd_q <= {dvd_q[QUOT_BITS-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// ===== design/motor_startup_frequency_ramp.sv =====
// Open-loop start-up ramp: each input beat is one PWM tick with a hall flag, and each
// tick yields one output beat with the phase counter, the sine period in ticks, the
// frequency in quarter hertz, the amplitude flag, the hall interval and the mode.
// The block waits for two hall updates, then raises the frequency by a quarter hertz
// whenever more than periods_per_step sine periods have passed, up to just over 125 Hz.
// A tick runs in steps when the output side is ready: the input is accepted, the serial
// restoring divider recomputes pwm_freq_hz*4/frequency one quotient bit a cycle, the
// quotient is collected and the output register is loaded. The input is not ready
// during that time. Configuration is written through cfg_we, cfg_index and cfg_data;
// the user must write it only while no tick is in flight; the block does not enforce it.
module motor_startup_frequency_ramp (
	input  logic                              clk,
	input  logic                              arst_n,
	msfr_in_if.sink                           ticks,
	msfr_out_if.source                        results,
	input  logic                              cfg_we,
	input  logic [msfr_pkg::IDX_BITS-1:0]     cfg_index,
	input  logic [msfr_pkg::CFG_BITS-1:0]     cfg_data
);
	import msfr_pkg::*;

	logic [PWM_BITS-1:0]  pwm_freq_q;
	freq_t                start_freq_q;
	logic [STEP_BITS-1:0] periods_step_q;

	mode_t                mode_q;
	count_t               phase_q;
	count_t               period_q;
	freq_t                freq_q;
	logic                 amp_q;
	logic [STEP_BITS-1:0] pdone_q;
	count_t               hcount_q;
	count_t               hint_q;

	seq_t seq_q, seq_d;
	logic accept;
	logic load_out;
	logic ovalid_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// next tick state
	logic                 adv;
	count_t               phase_n;
	logic [STEP_BITS-1:0] pdone_1, pdone_n;
	count_t               hcount_1, hcount_n;
	count_t               hint_n;
	mode_t                mode_n;
	freq_t                freq_n, freq_inc;
	logic                 amp_n;
	count_t               quot_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_freq_q     <= PWM_FREQ_RST;
			start_freq_q   <= START_FREQ_RST;
			periods_step_q <= PERIODS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PWM_FREQ:     pwm_freq_q     <= cfg_data[PWM_BITS-1:0];
				REG_START_FREQ:   start_freq_q   <= cfg_data[FREQ_BITS-1:0];
				REG_PERIODS_STEP: periods_step_q <= cfg_data[STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		adv      = phase_q < period_q;
		phase_n  = adv ? phase_q + 1'b1 : '0;
		pdone_1  = (!adv && pdone_q != PERIODS_MAX) ? pdone_q + 1'b1 : pdone_q;
		hcount_1 = (hcount_q != CNT_MAX) ? hcount_q + 1'b1 : hcount_q;
		hcount_n = ticks.hall_flag ? '0 : hcount_1;
		hint_n   = ticks.hall_flag ? hcount_1 : hint_q;
		freq_inc = freq_q + 1'b1;
		mode_n   = mode_q;
		freq_n   = freq_q;
		amp_n    = amp_q;
		pdone_n  = pdone_1;
		unique case (mode_q)
			MODE_WAIT_FIRST: begin
				amp_n  = 1'b0;
				freq_n = start_freq_q;
				if (ticks.hall_flag) mode_n = MODE_WAIT_SECOND;
			end
			MODE_WAIT_SECOND: begin
				amp_n  = 1'b0;
				freq_n = start_freq_q;
				if (ticks.hall_flag) mode_n = MODE_RAMP;
			end
			MODE_RAMP: begin
				if (freq_q <= FREQ_STOP_Q && pdone_1 > periods_step_q) begin
					freq_n  = freq_inc;
					amp_n   = freq_inc >= FREQ_FULL_Q;
					pdone_n = '0;
				end
			end
			default: mode_n = MODE_WAIT_FIRST;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seq_q <= SEQ_IDLE;
		else         seq_q <= seq_d;
	end

	always_comb begin
		seq_d       = seq_q;
		ticks.ready = 1'b0;
		load_out    = 1'b0;
		unique case (seq_q)
			SEQ_IDLE: begin
				ticks.ready = 1'b1;
				if (ticks.valid) seq_d = SEQ_DIV;
			end
			SEQ_DIV: begin
				if (div_rsp.done) seq_d = SEQ_PUB;
			end
			SEQ_PUB: begin
				if (!ovalid_q || results.ready) begin
					load_out = 1'b1;
					seq_d    = SEQ_IDLE;
				end
			end
			default: seq_d = SEQ_IDLE;
		endcase
	end

	assign accept = ticks.valid && ticks.ready;

	assign div_req.start    = accept;
	assign div_req.dividend = {pwm_freq_q, 2'b00};
	assign div_req.divisor  = freq_n;

	msfr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		if ({1'b0, 33'(div_rsp.quotient)} > {1'b0, 33'(CNT_MAX)}) quot_sat = CNT_MAX;
		else quot_sat = COUNT_BITS'(div_rsp.quotient);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_WAIT_FIRST;
			phase_q  <= '0;
			period_q <= '0;
			freq_q   <= START_FREQ_RST;
			amp_q    <= 1'b0;
			pdone_q  <= '0;
			hcount_q <= '0;
			hint_q   <= '0;
		end else begin
			if (accept) begin
				mode_q   <= mode_n;
				phase_q  <= phase_n;
				freq_q   <= freq_n;
				amp_q    <= amp_n;
				pdone_q  <= pdone_n;
				hcount_q <= hcount_n;
				hint_q   <= hint_n;
			end
			if (seq_q == SEQ_DIV && div_rsp.done) begin
				// zero frequency gives a saturated period
				period_q <= (freq_q == '0) ? CNT_MAX : quot_sat;
			end
		end
	end

	// output register, holds a beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load_out) begin
			ovalid_q <= 1'b1;
		end else if (results.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			results.phase_tick     <= FIELD_BITS'(phase_q);
			results.period_ticks   <= FIELD_BITS'(period_q);
			results.sine_freq_q    <= freq_q;
			results.full_amplitude <= amp_q;
			results.hall_period    <= FIELD_BITS'(hint_q);
			results.mode           <= mode_q;
		end
	end

	assign results.valid = ovalid_q;

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import msfr_pkg::*;

	localparam logic [IDX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int SEGMENT_TICKS = 100;
	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		field_t phase;
		field_t period;
		freq_t  freq;
		logic   amp;
		field_t hall;
		mode_t  mode;
	} ramp_out_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	msfr_in_if  tick_if ();
	msfr_out_if res_if ();

	motor_startup_frequency_ramp DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.ticks     (tick_if),
		.results   (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// predicted block state and register copies
	logic [PWM_BITS-1:0]  r_pwm;
	freq_t                r_start;
	logic [STEP_BITS-1:0] r_pps;
	mode_t                m_mode;
	count_t               m_phase;
	count_t               m_period;
	freq_t                m_freq;
	logic                 m_amp;
	logic [STEP_BITS-1:0] m_periods;
	count_t               m_hall_cnt;
	count_t               m_hall_ivl;

	ramp_out_t ramp_expect_q[$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	int        send_pct = 0;
	int        stall_pct = 0;

	function automatic ramp_out_t ramp_advance(input logic hall);
		ramp_out_t      o;
		longint unsigned quot;
		if (m_phase < m_period) begin
			m_phase = m_phase + 1'b1;
		end else begin
			m_phase = '0;
			if (m_periods != PERIODS_MAX)
				m_periods = m_periods + 1'b1;
		end
		if (m_hall_cnt != CNT_MAX)
			m_hall_cnt = m_hall_cnt + 1'b1;
		if (hall) begin
			m_hall_ivl = m_hall_cnt;
			m_hall_cnt = '0;
		end
		case (m_mode)
			MODE_WAIT_FIRST: begin
				m_amp = 1'b0;
				m_freq = r_start;
				if (hall)
					m_mode = MODE_WAIT_SECOND;
			end
			MODE_WAIT_SECOND: begin
				m_amp = 1'b0;
				m_freq = r_start;
				if (hall)
					m_mode = MODE_RAMP;
			end
			MODE_RAMP: begin
				if (m_freq <= FREQ_STOP_Q && m_periods > r_pps) begin
					m_freq = m_freq + 1'b1;
					m_amp = (m_freq >= FREQ_FULL_Q);
					m_periods = '0;
				end
			end
			default: m_mode = MODE_WAIT_FIRST;
		endcase
		// zero frequency gives the longest period
		if (m_freq == '0) begin
			m_period = CNT_MAX;
		end else begin
			quot = {r_pwm, 2'b00};
			quot = quot / m_freq;
			m_period = (quot > CNT_MAX) ? CNT_MAX : count_t'(quot);
		end
		o.phase = m_phase;
		o.period = m_period;
		o.freq = m_freq;
		o.amp = m_amp;
		o.hall = m_hall_ivl;
		o.mode = m_mode;
		return o;
	endfunction

	function automatic void check_field(input string fname, input field_t want, input field_t got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
		end
	endfunction

	always @(posedge clk) begin : scoreboard
		ramp_out_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PWM_FREQ:     r_pwm = cfg_data[PWM_BITS-1:0];
					REG_START_FREQ:   r_start = cfg_data[FREQ_BITS-1:0];
					REG_PERIODS_STEP: r_pps = cfg_data[STEP_BITS-1:0];
					default: ;
				endcase
			end
			if (tick_if.valid && tick_if.ready)
				ramp_expect_q.push_back(ramp_advance(tick_if.hall_flag));
			if (res_if.valid && res_if.ready) begin
				if (ramp_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result beat expected none actual phase_tick %0d",
							$time, res_if.phase_tick);
				end else begin
					want = ramp_expect_q.pop_front();
					check_field("phase_tick", want.phase, res_if.phase_tick);
					check_field("period_ticks", want.period, res_if.period_ticks);
					check_field("sine_freq_q", field_t'(want.freq), field_t'(res_if.sine_freq_q));
					check_field("full_amplitude", field_t'(want.amp), field_t'(res_if.full_amplitude));
					check_field("hall_period", want.hall, res_if.hall_period);
					check_field("mode", field_t'(want.mode), field_t'(res_if.mode));
				end
			end
			if (cfg_we || (tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	always @(posedge clk)
		res_if.ready <= ($urandom_range(99) >= stall_pct);

	task automatic send_tick(input logic hall);
		while ($urandom_range(99) < send_pct) begin
			tick_if.valid <= 1'b0;
			@(posedge clk);
		end
		tick_if.valid <= 1'b1;
		tick_if.hall_flag <= hall;
		// ready seen at the falling edge holds through the next rising edge
		do @(negedge clk); while (!tick_if.ready);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one edge first so the beat accepted at the last edge is already queued
	task automatic wait_idle();
		tick_if.valid <= 1'b0;
		@(posedge clk);
		while (ramp_expect_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// first ticks run on the reset register values, no hall yet
	task automatic test_reset_defaults();
		send_pct = 0;
		stall_pct = 0;
		repeat (3) send_tick(1'b0);
	endtask

	// zero and oversized start frequency, widest and zero pwm rate, ignored index, widest periods per step
	task automatic test_start_extremes();
		wait_idle();
		write_reg(REG_START_FREQ, '0);
		send_tick(1'b0);
		send_tick(1'b0);
		wait_idle();
		write_reg(REG_PWM_FREQ, '1);
		write_reg(REG_START_FREQ, '1);
		send_tick(1'b0);
		send_tick(1'b0);
		// period collapses under a running phase count
		wait_idle();
		write_reg(REG_PWM_FREQ, '0);
		send_tick(1'b0);
		send_tick(1'b0);
		wait_idle();
		write_reg(REG_UNUSED, '1);
		send_tick(1'b0);
		wait_idle();
		write_reg(REG_PERIODS_STEP, '1);
		send_tick(1'b0);
	endtask

	// two hall updates move the machine into the ramp
	task automatic test_hall_entry();
		wait_idle();
		write_reg(REG_PWM_FREQ, 20'd3);
		write_reg(REG_START_FREQ, 20'd1);
		write_reg(REG_PERIODS_STEP, '0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		repeat (4) send_tick(1'b0);
		send_tick(1'b1);
	endtask

	// mostly short periods so the ramp climbs, now and then long ones that later shrink
	task automatic test_ramp_random(input int s_pct, input int r_pct, input int segments);
		logic [CFG_BITS-1:0] pwm;
		logic [CFG_BITS-1:0] pps;
		send_pct = s_pct;
		stall_pct = r_pct;
		repeat (segments) begin
			wait_idle();
			if ($urandom_range(9) < 7) begin
				pwm = CFG_BITS'($urandom_range(8));
				pps = CFG_BITS'($urandom_range(1));
			end else begin
				case ($urandom_range(2))
					0: pwm = '1;
					1: pwm = CFG_BITS'(1);
					default: pwm = CFG_BITS'($urandom);
				endcase
				pps = ($urandom_range(2) == 0) ? CFG_BITS'(16'hFFFF) : CFG_BITS'($urandom);
			end
			write_reg(REG_PWM_FREQ, pwm);
			write_reg(REG_PERIODS_STEP, pps);
			write_reg(REG_START_FREQ, CFG_BITS'($urandom));
			if ($urandom_range(3) == 0)
				write_reg(REG_UNUSED, CFG_BITS'($urandom));
			repeat (SEGMENT_TICKS)
				send_tick($urandom_range(5) == 0);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PWM_FREQ;
		cfg_data <= '0;
		tick_if.valid <= 1'b0;
		tick_if.hall_flag <= 1'b0;
		r_pwm = PWM_FREQ_RST;
		r_start = START_FREQ_RST;
		r_pps = PERIODS_RST;
		m_mode = MODE_WAIT_FIRST;
		m_phase = '0;
		m_period = '0;
		m_freq = START_FREQ_RST;
		m_amp = 1'b0;
		m_periods = '0;
		m_hall_cnt = '0;
		m_hall_ivl = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_start_extremes();
		test_hall_entry();
		test_ramp_random(0, 0, 5);
		test_ramp_random(57, 0, 5);
		test_ramp_random(0, 57, 5);
		test_ramp_random(18, 18, 5);

		wait_idle();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && ramp_expect_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
design/msfr_pkg.sv
design/msfr_if.sv
design/msfr_div.sv
design/motor_startup_frequency_ramp.sv
tb/tb.sv
